### hdl/ps2ied_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PS/2 input event decoder package
// Shared types and codes for the front end, request queue and event emitter.
// ---------------------------------------------------------------------------
package ps2ied_pkg;

   // Result event kinds as seen on the response channel.
   typedef enum logic [2:0] {
      EV_MOVE     = 3'd0,
      EV_BUTTON   = 3'd1,
      EV_KEY_DOWN = 3'd2,
      EV_KEY_UP   = 3'd3,
      EV_SYSTEM   = 3'd4
   } event_kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MOUSE_LISTENER    = 2'd0,
      CSR_KEYBOARD_LISTENER = 2'd1,
      CSR_SYSTEM_TARGET     = 2'd2
   } csr_index_type;

   localparam logic [7:0] SYS_KEY_DOWN = 8'd1;
   localparam logic [7:0] SYS_KEY_UP   = 8'd129;

   // Event mask slots of one decoded request.
   localparam int SLOT_HEAD   = 0;  // move, key or system event
   localparam int SLOT_LEFT   = 1;
   localparam int SLOT_MIDDLE = 2;
   localparam int SLOT_RIGHT  = 3;
   localparam int NUM_SLOTS   = 4;

   // One decoded request: which events to emit and the data they carry.
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      event_kind_type       head_kind;
      logic signed [9:0]    delta_x;
      logic signed [9:0]    delta_y;
      logic [6:0]           key_code;
      logic [2:0]           levels;     // bit0 left, bit1 middle, bit2 right
   } job_type;

endpackage

### hdl/ps2ied_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PS/2 decoder front end
// Accepts bytes, assembles mouse packets, tracks button levels and turns
// each byte into a job of pending events.
// ---------------------------------------------------------------------------
module ps2ied_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_from_aux,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic                csr_write_data,
   output logic                push_valid,
   input  logic                push_ready,
   output ps2ied_pkg::job_type push_job
);
   import ps2ied_pkg::*;

   logic       mouse_en_ff, mouse_en_in;
   logic       kbd_en_ff, kbd_en_in;
   logic       sys_en_ff, sys_en_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] head_ff [2];
   logic [2:0] levels_ff, levels_in;

   logic       accept;
   logic       packet_done;
   logic [2:0] now_levels;
   job_type    job;

   assign req_ready   = push_ready;
   assign accept      = req_valid && req_ready;
   assign packet_done = req_from_aux && (count_ff >= 2'd2);
   assign now_levels  = {head_ff[0][1], head_ff[0][2], head_ff[0][0]};

   // Configuration writes; an index past the list is ignored.
   always_comb begin
      mouse_en_in = mouse_en_ff;
      kbd_en_in   = kbd_en_ff;
      sys_en_in   = sys_en_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MOUSE_LISTENER:    mouse_en_in = csr_write_data;
            CSR_KEYBOARD_LISTENER: kbd_en_in   = csr_write_data;
            CSR_SYSTEM_TARGET:     sys_en_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in  = count_ff;
      levels_in = levels_ff;
      if (accept && req_from_aux) begin
         if (packet_done) begin
            count_in  = 2'd0;
            levels_in = now_levels;
         end else begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_comb begin
      job           = '0;
      job.head_kind = EV_MOVE;
      if (req_from_aux) begin
         job.delta_x = {head_ff[0][4], head_ff[0][4], head_ff[1]};
         job.delta_y = 10'sd0 - $signed({head_ff[0][5], head_ff[0][5], req_data_byte});
         job.levels  = now_levels;
         if (packet_done && mouse_en_ff) begin
            job.mask[SLOT_HEAD] = (job.delta_x != 10'sd0) || (job.delta_y != 10'sd0);
            job.mask[SLOT_RIGHT:SLOT_LEFT] = now_levels ^ levels_ff;
         end
      end else if (req_data_byte == SYS_KEY_DOWN) begin
         job.head_kind       = EV_SYSTEM;
         job.mask[SLOT_HEAD] = sys_en_ff;
      end else if (req_data_byte != SYS_KEY_UP) begin
         job.head_kind       = req_data_byte[7] ? EV_KEY_UP : EV_KEY_DOWN;
         job.key_code        = req_data_byte[6:0];
         job.mask[SLOT_HEAD] = kbd_en_ff;
      end
   end

   assign push_valid = req_valid && (job.mask != '0);
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_en_ff <= 1'b0;
         kbd_en_ff   <= 1'b0;
         sys_en_ff   <= 1'b1;
         count_ff    <= 2'd0;
         levels_ff   <= 3'd0;
      end else begin
         mouse_en_ff <= mouse_en_in;
         kbd_en_ff   <= kbd_en_in;
         sys_en_ff   <= sys_en_in;
         count_ff    <= count_in;
         levels_ff   <= levels_in;
      end
   end

   // Packet head bytes hold no reset; they are written before use.
   always_ff @(posedge clock) begin
      if (accept && req_from_aux && !packet_done) begin
         head_ff[count_ff[0]] <= req_data_byte;
      end
   end

endmodule

### hdl/ps2ied_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PS/2 decoder job queue
// Two-entry queue that decouples the front end from the event emitter.
// ---------------------------------------------------------------------------
module ps2ied_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ps2ied_pkg::job_type push_job,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ps2ied_pkg::job_type pop_job
);
   import ps2ied_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hdl/ps2ied_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PS/2 decoder event emitter
// Walks the event mask of one job and issues one response per cycle, unless the
// response channel stalls, into a registered output stage.
// ---------------------------------------------------------------------------
module ps2ied_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  ps2ied_pkg::job_type pop_job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_event_kind,
   output logic signed [9:0]   rsp_delta_x,
   output logic signed [9:0]   rsp_delta_y,
   output logic [1:0]          rsp_button_id,
   output logic                rsp_pressed,
   output logic [6:0]          rsp_key_code,
   output logic                rsp_last_of_run
);
   import ps2ied_pkg::*;

   logic                 active_ff, active_in;
   job_type              job_ff, job_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;

   logic                 valid_ff, valid_in;
   logic [2:0]           kind_ff, kind_in;
   logic signed [9:0]    dx_ff, dx_in;
   logic signed [9:0]    dy_ff, dy_in;
   logic [1:0]           btn_ff, btn_in;
   logic                 prs_ff, prs_in;
   logic [6:0]           key_ff, key_in;
   logic                 last_ff, last_in;

   logic [NUM_SLOTS-1:0] sel;
   logic [NUM_SLOTS-1:0] rest;
   logic                 is_last;
   logic                 out_free;
   logic                 fire;
   logic                 load_job;

   // Lowest pending slot goes out first: head event, then left, middle, right.
   assign sel      = mask_ff & (~mask_ff + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
   assign rest     = mask_ff & ~sel;
   assign is_last  = (rest == '0);
   assign out_free = !valid_ff || rsp_ready;
   assign fire     = active_ff && out_free;
   assign load_job = pop_valid && (!active_ff || (fire && is_last));
   assign pop_ready = load_job;

   always_comb begin
      active_in = active_ff;
      job_in    = job_ff;
      mask_in   = mask_ff;
      if (load_job) begin
         active_in = 1'b1;
         job_in    = pop_job;
         mask_in   = pop_job.mask;
      end else if (fire) begin
         mask_in = rest;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      btn_in   = btn_ff;
      prs_in   = prs_ff;
      key_in   = key_ff;
      last_in  = last_ff;
      if (fire) begin
         valid_in = 1'b1;
         last_in  = is_last;
         if (sel[SLOT_HEAD]) begin
            kind_in = job_ff.head_kind;
            dx_in   = job_ff.delta_x;
            dy_in   = job_ff.delta_y;
            btn_in  = 2'd0;
            prs_in  = 1'b0;
            key_in  = job_ff.key_code;
         end else begin
            kind_in = EV_BUTTON;
            dx_in   = 10'sd0;
            dy_in   = 10'sd0;
            key_in  = 7'd0;
            if (sel[SLOT_LEFT]) begin
               btn_in = 2'd0;
               prs_in = job_ff.levels[0];
            end else if (sel[SLOT_MIDDLE]) begin
               btn_in = 2'd1;
               prs_in = job_ff.levels[1];
            end else begin
               btn_in = 2'd2;
               prs_in = job_ff.levels[2];
            end
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mask_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         mask_ff   <= mask_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      kind_ff <= kind_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      btn_ff  <= btn_in;
      prs_ff  <= prs_in;
      key_ff  <= key_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_delta_x      = dx_ff;
   assign rsp_delta_y      = dy_ff;
   assign rsp_button_id    = btn_ff;
   assign rsp_pressed      = prs_ff;
   assign rsp_key_code     = key_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

### hdl/ps2_input_event_decoder_unit.sv
`timescale 1ns / 1ps
// Each job passes the queue slot, the emitter's job register and the output stage in turn.
// Throughput: one request per cycle at the front end while the queue has room; the emitter
// issues one response per cycle unless rsp_ready stalls it; a request yields up to four events.
// The two-entry job queue lets the front end keep accepting while the emitter drains.
// Reset (synchronous, active high) clears packet progress, button levels, the queue and
// the output stage; mouse and keyboard listeners read absent, the system target present.
// ---------------------------------------------------------------------------
// PS/2 input event decoder
// Decodes keyboard scan bytes and three-byte mouse packets into move, button,
// key and system-key events.
// ---------------------------------------------------------------------------
module ps2_input_event_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_from_aux,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_kind,
   output logic signed [9:0] rsp_delta_x,
   output logic signed [9:0] rsp_delta_y,
   output logic [1:0]        rsp_button_id,
   output logic              rsp_pressed,
   output logic [6:0]        rsp_key_code,
   output logic              rsp_last_of_run,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic              csr_write_data
);
   import ps2ied_pkg::*;

   // Front end to queue.
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // Queue to emitter.
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // The front end classifies each byte in the cycle it is accepted and
   // updates packet and button state at once. Bytes that produce no events
   // (partial packets, the system key release, bytes without a listener)
   // never enter the queue.
   ps2ied_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_from_aux     (req_from_aux),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   // Jobs wait here so that a stalled response channel does not block the
   // front end until the queue fills.
   ps2ied_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // The emitter walks each job's event mask in order, marking the final
   // event of the job as the last of its run.
   ps2ied_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_job          (pop_job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_delta_x      (rsp_delta_x),
      .rsp_delta_y      (rsp_delta_y),
      .rsp_button_id    (rsp_button_id),
      .rsp_pressed      (rsp_pressed),
      .rsp_key_code     (rsp_key_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
